@@ rtl/core/cbd_pkg.sv @@
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared codes, address map bounds and size defaults for the CPU bus decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

    // Operation codes (s_tuser)
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // Region codes (m_tuser)
    localparam logic [1:0] REG_RAM = 2'd0;
    localparam logic [1:0] REG_PIC = 2'd1;
    localparam logic [1:0] REG_SND = 2'd2;
    localparam logic [1:0] REG_ROM = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_READONLY = 2'd2;

    // Address map bounds
    localparam logic [15:0] PIC_BASE   = 16'h2000;
    localparam logic [15:0] SND_BASE   = 16'h4000;
    localparam logic [15:0] SND_END    = 16'h4020;
    localparam logic [15:0] ROM_BASE   = 16'h8000;
    localparam logic [4:0]  SND_SPAN   = 5'h18;

    // Size defaults; RAM and ROM sizes are powers of two
    localparam int RAM_BYTES_DEF    = 2048;
    localparam int PICTURE_REGS_DEF = 8;
    localparam int ROM_BYTES_DEF    = 32768;

    localparam int OFFSET_W = 15;

endpackage

@@ rtl/core/console_cpu_bus_decoder.sv @@
// ----------------------------------------------------------------------------
// console_cpu_bus_decoder
// Decodes CPU bus accesses onto work RAM, picture registers, sound/IO and
// program ROM, and performs the read, write or ROM load.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                     | tuser
//  --------+-----+----------------------------------------+-----------
//  s_      | in  | bus_address[15:0], write_data[23:16]   | operation
//  m_      | out | read_data[7:0], local_offset[22:8],    | region
//          |     | status[24:23]                          |
//
//  One beat per cycle sustained while the sink keeps m_tready high; each result
//  passes the decode stage (decode + synchronous RAM/ROM read), then the output register.
//  After reset, s_tready stays low while a clearing pass writes zero to every
//  work RAM entry; picture registers clear at once.
//  A stall on m_tready holds the output register and the decode stage; the
//  memory read data is captured only on input beats, so it holds too.
//  Writes land at the accept edge, so a following read always sees them.
//
module console_cpu_bus_decoder #(
    parameter int RAM_BYTES    = cbd_pkg::RAM_BYTES_DEF,
    parameter int PICTURE_REGS = cbd_pkg::PICTURE_REGS_DEF,
    parameter int ROM_BYTES    = cbd_pkg::ROM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // bus_address[15:0], write_data[23:16]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[7:0], local_offset[22:8], status[24:23]
    output logic [1:0]  m_tuser    // region[1:0]
);

    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int PIC_AW = $clog2(PICTURE_REGS);
    localparam int ROM_AW = $clog2(ROM_BYTES);
    localparam int OW     = cbd_pkg::OFFSET_W;

    // Storage
    logic [7:0] ram_mem [RAM_BYTES];
    logic [7:0] rom_mem [ROM_BYTES];
    logic [7:0] pic_reg [PICTURE_REGS];
    logic [7:0] pic_next [PICTURE_REGS];

    logic [7:0] ram_q_reg;
    logic [7:0] rom_q_reg;

    // Clearing pass
    logic [RAM_AW-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_done_reg, clr_done_next;

    // Decode stage
    logic          p1_valid_reg, p1_valid_next;
    logic [1:0]    p1_region_reg;
    logic [OW-1:0] p1_offset_reg;
    logic [1:0]    p1_status_reg;
    logic          p1_rd_reg;
    logic [7:0]    p1_pic_reg;

    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    // Input fields
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;

    // Decode
    logic          dec_mapped;
    logic [1:0]    dec_region;
    logic [OW-1:0] dec_offset;
    logic [4:0]    snd_raw;

    // Item result and write enables
    logic [1:0]    res_region;
    logic [OW-1:0] res_offset;
    logic [1:0]    res_status;
    logic          res_rd;
    logic          ram_we_item;
    logic          pic_we;
    logic          rom_we;

    logic              s_acc;
    logic              out_free;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_wa;
    logic [7:0]        ram_wd;
    logic [7:0]        rd_data;

    assign op    = s_tuser;
    assign addr  = s_tdata[15:0];
    assign wdata = s_tdata[23:16];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = clr_done_reg && (!p1_valid_reg || out_free);
    assign s_acc    = s_tvalid && s_tready;

    // Address map
    always_comb begin
        snd_raw    = addr[4:0];
        dec_mapped = 1'b1;
        dec_region = cbd_pkg::REG_RAM;
        dec_offset = '0;
        if (addr < cbd_pkg::PIC_BASE) begin
            dec_region = cbd_pkg::REG_RAM;
            dec_offset = OW'(addr[RAM_AW-1:0]);
        end else if (addr < cbd_pkg::SND_BASE) begin
            dec_region = cbd_pkg::REG_PIC;
            dec_offset = OW'(addr[PIC_AW-1:0]);
        end else if (addr < cbd_pkg::SND_END) begin
            // fold 24..31 back onto 0..7
            dec_region = cbd_pkg::REG_SND;
            dec_offset = (snd_raw >= cbd_pkg::SND_SPAN) ?
                         OW'(snd_raw - cbd_pkg::SND_SPAN) : OW'(snd_raw);
        end else if (addr >= cbd_pkg::ROM_BASE) begin
            dec_region = cbd_pkg::REG_ROM;
            dec_offset = OW'(addr[ROM_AW-1:0]);
        end else begin
            dec_mapped = 1'b0;
        end
    end

    // Operation handling
    always_comb begin
        res_region  = '0;
        res_offset  = '0;
        res_status  = cbd_pkg::ST_OK;
        res_rd      = 1'b0;
        ram_we_item = 1'b0;
        pic_we      = 1'b0;
        rom_we      = 1'b0;
        case (op)
            cbd_pkg::OP_LOAD: begin
                res_region = cbd_pkg::REG_ROM;
                res_offset = OW'(addr[ROM_AW-1:0]);
                rom_we     = s_acc;
            end
            cbd_pkg::OP_READ: begin
                if (!dec_mapped) begin
                    res_status = cbd_pkg::ST_UNMAPPED;
                end else begin
                    res_region = dec_region;
                    res_offset = dec_offset;
                    res_rd     = (dec_region != cbd_pkg::REG_SND);
                end
            end
            cbd_pkg::OP_WRITE: begin
                if (!dec_mapped) begin
                    res_status = cbd_pkg::ST_UNMAPPED;
                end else begin
                    res_region = dec_region;
                    res_offset = dec_offset;
                    if (dec_region == cbd_pkg::REG_RAM) begin
                        ram_we_item = s_acc;
                    end else if (dec_region == cbd_pkg::REG_PIC) begin
                        pic_we = s_acc;
                    end else begin
                        res_status = cbd_pkg::ST_READONLY;
                    end
                end
            end
            default: begin
                // reserved operation: all-zero result, no state change
            end
        endcase
    end

    // Work RAM write port: clearing pass has it until done
    always_comb begin
        if (!clr_done_reg) begin
            ram_we = 1'b1;
            ram_wa = clr_addr_reg;
            ram_wd = '0;
        end else begin
            ram_we = ram_we_item;
            ram_wa = addr[RAM_AW-1:0];
            ram_wd = wdata;
        end
    end

    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == RAM_AW'(RAM_BYTES - 1)) begin
                clr_done_next = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PICTURE_REGS; i++) begin
            pic_next[i] = pic_reg[i];
        end
        if (pic_we) begin
            pic_next[addr[PIC_AW-1:0]] = wdata;
        end
    end

    // Memories: capture read data only on input beats so it holds on stalls
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_wa] <= ram_wd;
        end
        if (s_acc) begin
            ram_q_reg <= ram_mem[addr[RAM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (rom_we) begin
            rom_mem[addr[ROM_AW-1:0]] <= wdata;
        end
        if (s_acc) begin
            rom_q_reg <= rom_mem[addr[ROM_AW-1:0]];
        end
    end

    // Pick the read byte and advance the decode stage into the output register
    always_comb begin
        rd_data = '0;
        if (p1_rd_reg) begin
            case (p1_region_reg)
                cbd_pkg::REG_RAM: rd_data = ram_q_reg;
                cbd_pkg::REG_PIC: rd_data = p1_pic_reg;
                cbd_pkg::REG_ROM: rd_data = rom_q_reg;
                default:          rd_data = '0;
            endcase
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_free) begin
            m_tvalid_next = p1_valid_reg;
            m_tdata_next  = {7'd0, p1_status_reg, p1_offset_reg, rd_data};
            m_tuser_next  = p1_region_reg;
            p1_valid_next = 1'b0;
        end
        if (s_acc) begin
            p1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < PICTURE_REGS; i++) begin
                pic_reg[i] <= '0;
            end
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_done_reg <= clr_done_next;
            p1_valid_reg <= p1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int i = 0; i < PICTURE_REGS; i++) begin
                pic_reg[i] <= pic_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_region_reg <= res_region;
            p1_offset_reg <= res_offset;
            p1_status_reg <= res_status;
            p1_rd_reg     <= res_rd;
            p1_pic_reg    <= pic_reg[addr[PIC_AW-1:0]];
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/core/cbd_checker.sv @@
// ----------------------------------------------------------------------------
// cbd_checker
// Port-level checks for the CPU bus decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // No result beat straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Unmapped accesses return an all-zero payload
    a_unmapped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24:23] == cbd_pkg::ST_UNMAPPED
            |-> m_tdata[22:0] == 23'd0 && m_tuser == cbd_pkg::REG_RAM)
        else $error("unmapped result carries data");

    // Read-only errors name sound/IO or ROM and carry no read byte
    a_readonly_region: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24:23] == cbd_pkg::ST_READONLY
            |-> (m_tuser == cbd_pkg::REG_SND || m_tuser == cbd_pkg::REG_ROM)
                && m_tdata[7:0] == 8'd0)
        else $error("read-only error on a writable region");

    // Status code three and nonzero padding never appear
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[24:23] != 2'd3 && m_tdata[31:25] == 7'd0)
        else $error("bad status or padding");

endmodule

bind console_cpu_bus_decoder cbd_checker u_cbd_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives CPU bus accesses into the bus decoder and checks each result beat
// against a local model of the address map, work RAM, picture registers and
// ROM image, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

    // Operation code 3 is not in the package: the block answers it with zeros.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam int HOLDOFF_CYCLES = 300;     // long sink hold-off for pressure test
    localparam int TAIL_CYCLES    = 10;      // idle tail after the drain
    localparam int DRAIN_LIMIT    = 100000;  // cycles allowed to drain at the end
    localparam int RANDOM_ITEMS   = 380;

    localparam int OW     = cbd_pkg::OFFSET_W;
    localparam int RAM_AW = $clog2(cbd_pkg::RAM_BYTES_DEF);
    localparam int PIC_AW = $clog2(cbd_pkg::PICTURE_REGS_DEF);
    localparam int ROM_AW = $clog2(cbd_pkg::ROM_BYTES_DEF);

    typedef struct packed {
        logic [7:0]    rd;
        logic [1:0]    region;
        logic [OW-1:0] offset;
        logic [1:0]    status;
    } bus_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // bus_address[15:0], write_data[23:16]
    logic [1:0]  s_tuser;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_data[7:0], local_offset[22:8], status[24:23]
    logic [1:0]  m_tuser;   // region[1:0]

    // Local copy of the block's storage
    logic [7:0]    ram_image [cbd_pkg::RAM_BYTES_DEF];
    logic [7:0]    pic_image [cbd_pkg::PICTURE_REGS_DEF];
    logic [7:0]    rom_image [cbd_pkg::ROM_BYTES_DEF];
    bit            rom_loaded [cbd_pkg::ROM_BYTES_DEF];
    logic [OW-1:0] loaded_offsets [$];

    bus_result_t pending_results [$];
    bus_result_t want;
    int          fail_count;

    // Idle controls shared between the tests and the two drivers
    bit src_idle_on;
    bit sink_idle_on;
    bit sink_holdoff_req;

    console_cpu_bus_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one accepted access to the local storage and return its result.
    function automatic bus_result_t bus_access_result(logic [1:0] op, logic [15:0] addr,
                                                      logic [7:0] data);
        bus_result_t res;
        bit          mapped;
        res    = '0;
        mapped = 1'b1;
        if (op == cbd_pkg::OP_LOAD) begin
            res.offset = OW'(addr % cbd_pkg::ROM_BYTES_DEF);
            res.region = cbd_pkg::REG_ROM;
            rom_image[res.offset[ROM_AW-1:0]] = data;
            if (!rom_loaded[res.offset[ROM_AW-1:0]]) begin
                rom_loaded[res.offset[ROM_AW-1:0]] = 1'b1;
                loaded_offsets.push_back(res.offset);
            end
            return res;
        end
        if (op == OP_RESERVED) return res;

        // Address map: RAM, picture registers, sound/IO, hole, ROM
        if (addr < cbd_pkg::PIC_BASE) begin
            res.region = cbd_pkg::REG_RAM;
            res.offset = OW'(addr % cbd_pkg::RAM_BYTES_DEF);
        end else if (addr < cbd_pkg::SND_BASE) begin
            res.region = cbd_pkg::REG_PIC;
            res.offset = OW'((addr - cbd_pkg::PIC_BASE) % cbd_pkg::PICTURE_REGS_DEF);
        end else if (addr < cbd_pkg::SND_END) begin
            res.region = cbd_pkg::REG_SND;
            res.offset = OW'((addr - cbd_pkg::SND_BASE) % cbd_pkg::SND_SPAN);
        end else if (addr >= cbd_pkg::ROM_BASE) begin
            res.region = cbd_pkg::REG_ROM;
            res.offset = OW'((addr & 16'h7FFF) % cbd_pkg::ROM_BYTES_DEF);
        end else begin
            mapped = 1'b0;
        end

        if (!mapped) begin
            res.status = cbd_pkg::ST_UNMAPPED;
        end else if (op == cbd_pkg::OP_READ) begin
            case (res.region)
                cbd_pkg::REG_RAM: res.rd = ram_image[res.offset[RAM_AW-1:0]];
                cbd_pkg::REG_PIC: res.rd = pic_image[res.offset[PIC_AW-1:0]];
                cbd_pkg::REG_ROM: res.rd = rom_image[res.offset[ROM_AW-1:0]];
                default:          res.rd = 8'h00;   // sound/IO holds nothing
            endcase
        end else begin
            case (res.region)
                cbd_pkg::REG_RAM: ram_image[res.offset[RAM_AW-1:0]] = data;
                cbd_pkg::REG_PIC: pic_image[res.offset[PIC_AW-1:0]] = data;
                default:          res.status = cbd_pkg::ST_READONLY;
            endcase
        end
        return res;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch @%0t: %s", $time, msg);
    endtask

    // Offer one beat and hold it until accepted; predict at the accept edge.
    // tvalid stays high afterward so back-to-back beats need no extra edge.
    task automatic send_access(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        int gap;
        gap = src_idle_on ? idle_cycles() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(bus_access_result(op, addr, data));
    endtask

    // Compare each result beat with the oldest expectation, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected beat tdata=%h tuser=%h", m_tdata, m_tuser));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.rd)
                    note_failure($sformatf("read_data exp %h got %h", want.rd, m_tdata[7:0]));
                if (m_tuser !== want.region)
                    note_failure($sformatf("region exp %0d got %0d", want.region, m_tuser));
                if (m_tdata[22:8] !== want.offset)
                    note_failure($sformatf("local_offset exp %h got %h",
                                           want.offset, m_tdata[22:8]));
                if (m_tdata[24:23] !== want.status)
                    note_failure($sformatf("status exp %0d got %0d",
                                           want.status, m_tdata[24:23]));
                if (m_tdata[31:25] !== 7'd0)
                    note_failure($sformatf("tdata pad bits set: %h", m_tdata[31:25]));
            end
        end
    end

    // Sink: random stalls, stretches of steady ready, and one long hold-off
    // on request while the source keeps offering beats.
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_holdoff_req) begin
                sink_holdoff_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end else begin
                n = sink_idle_on ? idle_cycles() : 0;
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end else begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                end
            end
        end
    end

    // RAM and picture registers must read back zero once the clearing pass ends.
    task automatic test_after_reset();
        send_access(cbd_pkg::OP_READ, 16'h0000, 8'h00);
        send_access(cbd_pkg::OP_READ, 16'h1FFF, 8'hFF);
        send_access(cbd_pkg::OP_READ, 16'h2003, 8'h00);
        send_access(cbd_pkg::OP_READ, 16'h3FFF, 8'h00);
    endtask

    // Region boundaries, mirroring, every status and every operation.
    task automatic test_map_edges();
        send_access(cbd_pkg::OP_WRITE, 16'h0000, 8'hAA);
        send_access(cbd_pkg::OP_WRITE, 16'h07FF, 8'h55);
        send_access(cbd_pkg::OP_READ,  16'h0800, 8'h00);   // RAM mirror of 0x0000
        send_access(cbd_pkg::OP_READ,  16'h1FFF, 8'h00);   // top RAM mirror of 0x07FF
        send_access(cbd_pkg::OP_WRITE, 16'h2000, 8'h11);
        send_access(cbd_pkg::OP_WRITE, 16'h3FFF, 8'hFF);
        send_access(cbd_pkg::OP_READ,  16'h2008, 8'h00);   // picture register mirror
        send_access(cbd_pkg::OP_READ,  16'h2007, 8'h00);
        // sound/IO reads come back zero; offset wraps at 0x18
        send_access(cbd_pkg::OP_READ,  16'h4000, 8'h00);
        send_access(cbd_pkg::OP_READ,  16'h4017, 8'h00);
        send_access(cbd_pkg::OP_READ,  16'h4018, 8'h00);
        send_access(cbd_pkg::OP_READ,  16'h401F, 8'h00);
        send_access(cbd_pkg::OP_WRITE, 16'h4005, 8'h77);   // read-only region
        // hole between sound/IO and ROM
        send_access(cbd_pkg::OP_READ,  16'h4020, 8'h00);
        send_access(cbd_pkg::OP_WRITE, 16'h7FFF, 8'hFF);
        // ROM loads, including an address with bit 15 set
        send_access(cbd_pkg::OP_LOAD,  16'h0000, 8'hFF);
        send_access(cbd_pkg::OP_LOAD,  16'hFFFF, 8'h00);
        send_access(cbd_pkg::OP_LOAD,  16'h7FFE, 8'h5A);
        send_access(cbd_pkg::OP_READ,  16'h8000, 8'h00);
        send_access(cbd_pkg::OP_READ,  16'hFFFF, 8'h00);
        send_access(cbd_pkg::OP_READ,  16'hFFFE, 8'h00);
        send_access(cbd_pkg::OP_WRITE, 16'h8000, 8'h12);   // ROM is read-only
        send_access(cbd_pkg::OP_READ,  16'h8000, 8'h00);
        send_access(OP_RESERVED, 16'hFFFF, 8'hFF);
        send_access(OP_RESERVED, 16'h0000, 8'h00);
    endtask

    // One random access; ROM reads only target entries already loaded.
    task automatic send_random_access();
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        int          pick;
        pick = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        op   = $urandom_range(0, 1) ? cbd_pkg::OP_WRITE : cbd_pkg::OP_READ;
        if (pick < 20) begin
            // narrow window plus mirror bits so reads hit earlier writes
            if ($urandom_range(0, 1))
                addr = 16'($urandom_range(0, 15) | ($urandom_range(0, 3) << 11));
            else
                addr = 16'($urandom_range(0, 16'h1FFF));
        end else if (pick < 35) begin
            addr = 16'(cbd_pkg::PIC_BASE + $urandom_range(0, 16'h1FFF));
        end else if (pick < 45) begin
            addr = 16'(cbd_pkg::SND_BASE + $urandom_range(0, 31));
        end else if (pick < 53) begin
            addr = 16'($urandom_range(cbd_pkg::SND_END, cbd_pkg::ROM_BASE - 1));
        end else if (pick < 68 || (pick < 83 && loaded_offsets.size() == 0)) begin
            op   = cbd_pkg::OP_LOAD;
            addr = 16'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 16'hFFFF));
        end else if (pick < 83) begin
            op   = cbd_pkg::OP_READ;
            addr = cbd_pkg::ROM_BASE |
                   16'(loaded_offsets[$urandom_range(0, loaded_offsets.size() - 1)]);
        end else if (pick < 88) begin
            op   = cbd_pkg::OP_WRITE;
            addr = cbd_pkg::ROM_BASE | 16'($urandom_range(0, 16'h7FFF));
        end else if (pick < 93) begin
            op   = OP_RESERVED;
            addr = 16'($urandom_range(0, 16'hFFFF));
        end else begin
            op   = 2'($urandom_range(0, 3));
            addr = 16'($urandom_range(0, 16'hFFFF));
            // turn a read of an unloaded ROM entry into a write
            if (op == cbd_pkg::OP_READ && addr >= cbd_pkg::ROM_BASE &&
                !rom_loaded[addr[ROM_AW-1:0]])
                op = cbd_pkg::OP_WRITE;
        end
        send_access(op, addr, data);
    endtask

    task automatic test_random_traffic();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (RANDOM_ITEMS) send_random_access();
    endtask

    // Full rate on both sides.
    task automatic test_full_rate();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (60) send_random_access();
    endtask

    // Hold the sink off while the source streams, so the block backs up.
    task automatic test_backpressure();
        src_idle_on      = 1'b0;
        sink_idle_on     = 1'b1;
        sink_holdoff_req = 1'b1;
        repeat (40) send_random_access();
    endtask

    initial begin : main
        int waited;
        aresetn          <= 1'b0;
        s_tvalid         <= 1'b0;
        s_tdata          <= '0;
        s_tuser          <= cbd_pkg::OP_READ;
        m_tready         <= 1'b0;
        fail_count       = 0;
        src_idle_on      = 1'b0;
        sink_idle_on     = 1'b0;
        sink_holdoff_req = 1'b0;
        foreach (ram_image[i]) ram_image[i] = 8'h00;
        foreach (pic_image[i]) pic_image[i] = 8'h00;
        foreach (rom_image[i]) rom_image[i] = 8'h00;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_map_edges();
        test_random_traffic();
        test_full_rate();
        test_backpressure();

        // drop valid and drain
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run including the clearing pass.
    initial begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cbd_pkg.sv
rtl/core/console_cpu_bus_decoder.sv
rtl/core/cbd_checker.sv
test/testbench.sv
